>>> sv/rfhs_pkg.sv
// Shared types, codes and helpers for the real FFT Hermitian split butterfly.
package rfhs_pkg;

   // Field widths.
   localparam int unsigned DATA_W  = 16;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   // Internal widths: butterfly sums, products, shifted products, final sums.
   localparam int unsigned SUM_W  = DATA_W + 1;
   localparam int unsigned PROD_W = 2 * SUM_W;
   localparam int unsigned ACC_W  = PROD_W + 2;
   localparam int unsigned FIN_W  = ACC_W + 2;

   // Reset values of the registers.
   localparam logic [SHIFT_W-1:0] TWIDDLE_SHIFT_RESET = SHIFT_W'(15);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_EDGE = 2'd0;
   localparam logic [OP_W-1:0] OP_PAIR = 2'd1;
   localparam logic [OP_W-1:0] OP_MID  = 2'd2;

   // Register indexes.
   localparam logic REG_INVERSE_MODE  = 1'b0;
   localparam logic REG_TWIDDLE_SHIFT = 1'b1;

   // Saturation bounds.
   localparam logic signed [DATA_W-1:0] SAT_MAX = 16'sd32767;
   localparam logic signed [DATA_W-1:0] SAT_MIN = -16'sd32768;

   typedef logic signed [DATA_W-1:0] sample_type;

   // Clamp a wide signed value to the 16-bit range.
   function automatic sample_type sat16(input logic signed [FIN_W-1:0] x);
      sample_type res;
      if (x > FIN_W'(SAT_MAX)) begin
         res = SAT_MAX;
      end else if (x < FIN_W'(SAT_MIN)) begin
         res = SAT_MIN;
      end else begin
         res = x[DATA_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> sv/real_fft_hermitian_split_top.sv
// Top level of the real FFT Hermitian split butterfly with its register port.

// One Hermitian split butterfly per request for a real FFT computed as a
// half-length complex FFT. The block is a four-stage pipeline: butterfly
// sums, the four twiddle products, rounding and shift, then final sums with
// optional halving and saturation into the output register. It takes one
// request per clock cycle, and each result passes through the s1, s2 and s3
// registers and the output register; the pipeline stalls as a whole only
// when a finished result is held by the downstream side and no stage has a
// bubble to absorb it. A request with op 3 is consumed and produces no
// result. The two configuration registers (inverse mode at byte 0, twiddle
// shift at byte 4) may only be written while no request is in flight.
module real_fft_hermitian_split_top
   import rfhs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic signed [DATA_W-1:0] req_in_lo_re,
   input  logic signed [DATA_W-1:0] req_in_lo_im,
   input  logic signed [DATA_W-1:0] req_in_hi_re,
   input  logic signed [DATA_W-1:0] req_in_hi_im,
   input  logic signed [DATA_W-1:0] req_tw_re,
   input  logic signed [DATA_W-1:0] req_tw_im,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [DATA_W-1:0] rsp_out_lo_re,
   output logic signed [DATA_W-1:0] rsp_out_lo_im,
   output logic signed [DATA_W-1:0] rsp_out_hi_re,
   output logic signed [DATA_W-1:0] rsp_out_hi_im,
   output logic                  rsp_hi_valid,
   // Register port.
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // Configuration registers.
   logic               inverse_mode_ff;
   logic [SHIFT_W-1:0] twiddle_shift_ff;

   // Stage enables.
   logic adv1, adv2, adv3, adv4;

   // Stage 1: butterfly sums and twiddle.
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [SUM_W-1:0] s1_sr_ff, s1_sr_in;
   logic signed [SUM_W-1:0] s1_si_ff, s1_si_in;
   logic signed [SUM_W-1:0] s1_dr_ff, s1_dr_in;
   logic signed [SUM_W-1:0] s1_di_ff, s1_di_in;
   logic signed [SUM_W-1:0] s1_wr_ff, s1_wr_in;
   logic signed [SUM_W-1:0] s1_wi_ff, s1_wi_in;
   logic                    s1_halve_ff, s1_halve_in;
   logic                    s1_edge_ff, s1_edge_in;
   logic                    s1_hiv_ff, s1_hiv_in;

   // Stage 2: products.
   logic                     s2_valid_ff;
   logic signed [PROD_W-1:0] s2_p_rr_ff, s2_p_rr_in;
   logic signed [PROD_W-1:0] s2_p_ii_ff, s2_p_ii_in;
   logic signed [PROD_W-1:0] s2_p_ri_ff, s2_p_ri_in;
   logic signed [PROD_W-1:0] s2_p_ir_ff, s2_p_ir_in;
   logic signed [SUM_W-1:0]  s2_sr_ff, s2_si_ff;
   logic                     s2_halve_ff, s2_edge_ff, s2_hiv_ff;

   // Stage 3: rounded and shifted twiddle product.
   logic                    s3_valid_ff;
   logic signed [ACC_W-1:0] s3_tr_ff, s3_tr_in;
   logic signed [ACC_W-1:0] s3_ti_ff, s3_ti_in;
   logic signed [SUM_W-1:0] s3_sr_ff, s3_si_ff;
   logic                    s3_halve_ff, s3_edge_ff, s3_hiv_ff;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-1:0] re_acc, im_acc;

   // Stage 4: output register.
   logic                    rsp_valid_ff;
   sample_type              lo_re_ff, lo_re_in;
   sample_type              lo_im_ff, lo_im_in;
   sample_type              hi_re_ff, hi_re_in;
   sample_type              hi_im_ff, hi_im_in;
   logic                    hiv_ff;
   logic signed [FIN_W-1:0] fa, fb, fc, fd;
   logic signed [FIN_W-1:0] ha, hb, hc, hd;

   // Register writes take effect in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_mode_ff  <= 1'b0;
         twiddle_shift_ff <= TWIDDLE_SHIFT_RESET;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_INVERSE_MODE:  inverse_mode_ff  <= pwdata[0];
            REG_TWIDDLE_SHIFT: twiddle_shift_ff <= pwdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      case (paddr[2])
         REG_INVERSE_MODE:  prdata = {{(CSR_DATA_W-1){1'b0}}, inverse_mode_ff};
         REG_TWIDDLE_SHIFT: prdata = {{(CSR_DATA_W-SHIFT_W){1'b0}}, twiddle_shift_ff};
         default:           prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   // Pipeline flow control: a stage moves when its successor can take it.
   assign adv4 = !rsp_valid_ff || rsp_ready;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   // Stage 1: choose the butterfly operands for the requested case.
   // The edge case forces a zero product so the shared datapath adds nothing.
   always_comb begin
      s1_sr_in = '0;
      s1_si_in = '0;
      s1_dr_in = '0;
      s1_di_in = '0;
      case (req_op)
         OP_EDGE: begin
            s1_sr_in = SUM_W'(req_in_lo_re) + SUM_W'(req_in_lo_im);
            s1_si_in = SUM_W'(req_in_lo_re) - SUM_W'(req_in_lo_im);
         end
         OP_PAIR: begin
            s1_sr_in = SUM_W'(req_in_lo_re) + SUM_W'(req_in_hi_re);
            s1_si_in = SUM_W'(req_in_lo_im) - SUM_W'(req_in_hi_im);
            s1_dr_in = SUM_W'(req_in_lo_re) - SUM_W'(req_in_hi_re);
            s1_di_in = SUM_W'(req_in_lo_im) + SUM_W'(req_in_hi_im);
         end
         OP_MID: begin
            s1_sr_in = SUM_W'(req_in_lo_re) + SUM_W'(req_in_lo_re);
            s1_di_in = SUM_W'(req_in_lo_im) + SUM_W'(req_in_lo_im);
         end
         default: ;
      endcase
      s1_wr_in    = SUM_W'(req_tw_re);
      s1_wi_in    = inverse_mode_ff ? -SUM_W'(req_tw_im) : SUM_W'(req_tw_im);
      s1_halve_in = !inverse_mode_ff && (req_op != OP_EDGE);
      s1_edge_in  = (req_op == OP_EDGE);
      s1_hiv_in   = (req_op == OP_PAIR) || ((req_op == OP_EDGE) && !inverse_mode_ff);
      s1_valid_in = req_valid && ((req_op == OP_EDGE) || (req_op == OP_PAIR) ||
                                  (req_op == OP_MID));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_sr_ff    <= s1_sr_in;
         s1_si_ff    <= s1_si_in;
         s1_dr_ff    <= s1_dr_in;
         s1_di_ff    <= s1_di_in;
         s1_wr_ff    <= s1_wr_in;
         s1_wi_ff    <= s1_wi_in;
         s1_halve_ff <= s1_halve_in;
         s1_edge_ff  <= s1_edge_in;
         s1_hiv_ff   <= s1_hiv_in;
      end
   end

   // Stage 2: the four partial products of the complex multiply.
   assign s2_p_rr_in = PROD_W'(s1_dr_ff) * PROD_W'(s1_wr_ff);
   assign s2_p_ii_in = PROD_W'(s1_di_ff) * PROD_W'(s1_wi_ff);
   assign s2_p_ri_in = PROD_W'(s1_dr_ff) * PROD_W'(s1_wi_ff);
   assign s2_p_ir_in = PROD_W'(s1_di_ff) * PROD_W'(s1_wr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_p_rr_ff  <= s2_p_rr_in;
         s2_p_ii_ff  <= s2_p_ii_in;
         s2_p_ri_ff  <= s2_p_ri_in;
         s2_p_ir_ff  <= s2_p_ir_in;
         s2_sr_ff    <= s1_sr_ff;
         s2_si_ff    <= s1_si_ff;
         s2_halve_ff <= s1_halve_ff;
         s2_edge_ff  <= s1_edge_ff;
         s2_hiv_ff   <= s1_hiv_ff;
      end
   end

   // Stage 3: combine products, add the rounding half, shift arithmetically.
   // A shift of zero adds no rounding half.
   always_comb begin
      rnd = '0;
      if (twiddle_shift_ff != '0) begin
         rnd = ACC_W'(1) <<< (twiddle_shift_ff - SHIFT_W'(1));
      end
      re_acc   = ACC_W'(s2_p_rr_ff) - ACC_W'(s2_p_ii_ff) + rnd;
      im_acc   = ACC_W'(s2_p_ri_ff) + ACC_W'(s2_p_ir_ff) + rnd;
      s3_tr_in = re_acc >>> twiddle_shift_ff;
      s3_ti_in = im_acc >>> twiddle_shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_tr_ff    <= s3_tr_in;
         s3_ti_ff    <= s3_ti_in;
         s3_sr_ff    <= s2_sr_ff;
         s3_si_ff    <= s2_si_ff;
         s3_halve_ff <= s2_halve_ff;
         s3_edge_ff  <= s2_edge_ff;
         s3_hiv_ff   <= s2_hiv_ff;
      end
   end

   // Stage 4: final sums, rounded halving (forward, non-edge), saturation.
   always_comb begin
      fa = FIN_W'(s3_sr_ff) + FIN_W'(s3_tr_ff);
      fb = FIN_W'(s3_si_ff) + FIN_W'(s3_ti_ff);
      fc = FIN_W'(s3_sr_ff) - FIN_W'(s3_tr_ff);
      fd = FIN_W'(s3_ti_ff) - FIN_W'(s3_si_ff);
      ha = s3_halve_ff ? ((fa + FIN_W'(1)) >>> 1) : fa;
      hb = s3_halve_ff ? ((fb + FIN_W'(1)) >>> 1) : fb;
      hc = s3_halve_ff ? ((fc + FIN_W'(1)) >>> 1) : fc;
      hd = s3_halve_ff ? ((fd + FIN_W'(1)) >>> 1) : fd;
      lo_re_in = sat16(ha);
      lo_im_in = sat16(hb);
      hi_re_in = '0;
      hi_im_in = '0;
      // The forward edge case repeats the difference word as the Nyquist bin.
      if (s3_hiv_ff) begin
         if (s3_edge_ff) begin
            hi_re_in = sat16(hb);
         end else begin
            hi_re_in = sat16(hc);
            hi_im_in = sat16(hd);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv4) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         lo_re_ff <= lo_re_in;
         lo_im_ff <= lo_im_in;
         hi_re_ff <= hi_re_in;
         hi_im_ff <= hi_im_in;
         hiv_ff   <= s3_hiv_ff;
      end
   end

   // Result ports.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_lo_re = lo_re_ff;
   assign rsp_out_lo_im = lo_im_ff;
   assign rsp_out_hi_re = hi_re_ff;
   assign rsp_out_hi_im = hi_im_ff;
   assign rsp_hi_valid  = hiv_ff;

endmodule
